// ===== hdl/lss_pkg.sv =====
package lss_pkg;

    localparam int unsigned FIELD_W   = 24;
    localparam int unsigned YAW_W     = 15;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned MUL_W     = 25;
    localparam int unsigned PROD_W    = 2 * MUL_W;
    localparam int unsigned WIDE_W    = 48;
    localparam int unsigned ACC_W     = 42;
    localparam int unsigned ANGLE_W   = 17;
    localparam int unsigned ITER_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS     = 2'd2;

    localparam logic [CFG_W-1:0] WHEELBASE_RESET = 16'd11424;
    localparam logic [CFG_W-1:0] HEADING_RESET   = 16'd4096;
    localparam logic [CFG_W-1:0] CROSS_RESET     = 16'd4096;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_VEC  = 5'b00100,
        S_SUM  = 5'b01000,
        S_HOLD = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_NORM = 3'b010,
        C_ROT  = 3'b100
    } cordic_state_t;

    typedef struct packed {
        logic start;
    } cordic_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_sts_t;

    // round(atan(2^-i) * 65536)
    function automatic logic [15:0] atan_q16(input logic [ITER_W-1:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/lss_mul.sv =====
module lss_mul
    import lss_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== hdl/lss_cordic.sv =====
module lss_cordic
    import lss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cordic_ctl_t        ctl,
    input  logic [WIDE_W-1:0]  num,
    input  logic [WIDE_W-1:0]  den,
    output cordic_sts_t        sts,
    output logic [ANGLE_W-1:0] angle
);

    cordic_state_t      state_reg;
    logic               done_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [WIDE_W-1:0]  a_reg;
    logic [WIDE_W-1:0]  b_reg;
    logic signed [32:0] x_reg;
    logic signed [32:0] y_reg;
    logic signed [18:0] z_reg;

    logic [WIDE_W-1:0]  ab_or;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [18:0] step_angle;
    logic               rot_pos;

    assign ab_or      = a_reg | b_reg;
    assign xs         = x_reg >>> iter_reg;
    assign ys         = y_reg >>> iter_reg;
    assign step_angle = signed'({3'b000, atan_q16(iter_reg)});
    assign rot_pos    = !y_reg[32] && (y_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            done_reg <= (state_reg == C_ROT) && (iter_reg == '1);
            unique case (state_reg)
                C_IDLE:
                begin
                    if (ctl.start)
                    begin
                        state_reg <= C_NORM;
                    end
                end
                C_NORM:
                begin
                    // scale both into [2^29, 2^30) by the larger of the two
                    if (ab_or[WIDE_W-1:30] == '0 && ab_or[29])
                    begin
                        iter_reg  <= '0;
                        state_reg <= C_ROT;
                    end
                end
                C_ROT:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == '1)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                if (ctl.start)
                begin
                    a_reg <= num;
                    b_reg <= den;
                end
            end
            C_NORM:
            begin
                if (ab_or[WIDE_W-1:30] != '0)
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                end
                else if (!ab_or[29])
                begin
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg << 1;
                end
                else
                begin
                    x_reg <= signed'({3'b000, b_reg[29:0]});
                    y_reg <= signed'({3'b000, a_reg[29:0]});
                    z_reg <= '0;
                end
            end
            C_ROT:
            begin
                if (rot_pos)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + step_angle;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - step_angle;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sts.busy = (state_reg != C_IDLE);
    assign sts.done = done_reg;
    assign angle    = z_reg[18] ? '0 : z_reg[ANGLE_W-1:0];

endmodule

// ===== hdl/lookahead_stanley_steering.sv =====
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   command, goal_x, goal_y, target_heading, lateral_error
// output    out        out_valid / out_stall steering_angle, saturated, goal_at_origin
// config    in         cfg_write_enable      cfg_index, cfg_data
//
// An update item (command 0) does not stall the input and gives no result.
// A goal item runs six multiplier passes and, unless the pursuit term is zero,
// the one-bit normalizer and the 16 CORDIC steps before its result is loaded.
// in_stall is high from the cycle after a goal transfer until its result sits
// in the output register; a stalled output holds the block in its final state.
// Reset is asynchronous, active low; control and config registers return to defaults.
module lookahead_stanley_steering
    import lss_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_enable,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic signed [FIELD_W-1:0] goal_x,
    input  logic signed [FIELD_W-1:0] goal_y,
    input  logic signed [YAW_W-1:0]   target_heading,
    input  logic signed [FIELD_W-1:0] lateral_error,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [FIELD_W-1:0] steering_angle,
    output logic                      saturated,
    output logic                      goal_at_origin
);

    state_t                    state_reg;
    logic [2:0]                step_reg;
    logic                      start_reg;
    logic                      out_valid_reg;

    logic [CFG_W-1:0]          wheelbase_reg;
    logic [CFG_W-1:0]          heading_gain_reg;
    logic [CFG_W-1:0]          cross_gain_reg;
    logic signed [FIELD_W-1:0] err_reg;

    logic [FIELD_W-1:0]        ax_reg;
    logic [FIELD_W-1:0]        ay_reg;
    logic signed [YAW_W-1:0]   yaw_reg;
    logic                      gy_neg_reg;
    logic                      origin_reg;
    logic                      need_reg;
    logic [WIDE_W-1:0]         den_reg;
    logic [WIDE_W-1:0]         num_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [17:0]        pursuit_reg;

    logic signed [FIELD_W-1:0] angle_out_reg;
    logic                      sat_out_reg;
    logic                      origin_out_reg;

    logic                      in_xfer;
    logic                      out_free;
    logic                      start_next;
    logic                      out_valid_next;
    logic signed [MUL_W-1:0]   op_a;
    logic signed [MUL_W-1:0]   op_b;
    logic signed [PROD_W-1:0]  prod;
    cordic_ctl_t               cordic_ctl;
    cordic_sts_t               cordic_sts;
    logic [ANGLE_W-1:0]        cordic_angle;
    logic signed [ACC_W-1:0]   total;
    logic signed [ACC_W-1:0]   rounded_full;
    logic signed [29:0]        rounded;
    logic                      over;
    logic [FIELD_W-1:0]        abs_x;
    logic [FIELD_W-1:0]        abs_y;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign abs_x = goal_x[FIELD_W-1] ? (~goal_x + 1'b1) : goal_x;
    assign abs_y = goal_y[FIELD_W-1] ? (~goal_y + 1'b1) : goal_y;

    // Configuration writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg    <= WHEELBASE_RESET;
            heading_gain_reg <= HEADING_RESET;
            cross_gain_reg   <= CROSS_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_WHEELBASE: wheelbase_reg    <= cfg_data;
                REG_HEADING:   heading_gain_reg <= cfg_data;
                REG_CROSS:     cross_gain_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Operand select for the shared multiplier: x^2, y^2, W*y, err*gain, yaw*gain.
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                op_a = signed'({1'b0, ax_reg});
                op_b = signed'({1'b0, ax_reg});
            end
            3'd1:
            begin
                op_a = signed'({1'b0, ay_reg});
                op_b = signed'({1'b0, ay_reg});
            end
            3'd2:
            begin
                op_a = signed'({9'd0, wheelbase_reg});
                op_b = signed'({1'b0, ay_reg});
            end
            3'd3:
            begin
                op_a = signed'({err_reg[FIELD_W-1], err_reg});
                op_b = signed'({{9{cross_gain_reg[CFG_W-1]}}, cross_gain_reg});
            end
            default:
            begin
                op_a = signed'({{10{yaw_reg[YAW_W-1]}}, yaw_reg});
                op_b = signed'({{9{heading_gain_reg[CFG_W-1]}}, heading_gain_reg});
            end
        endcase
    end

    lss_mul u_mul (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod)
    );

    assign cordic_ctl.start = start_reg;

    lss_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cordic_ctl),
        .num   (num_reg),
        .den   (den_reg),
        .sts   (cordic_sts),
        .angle (cordic_angle)
    );

    // Final sum: round half up to Q.12, then clip to 24 bits.
    assign total        = acc_reg + signed'({{16{pursuit_reg[17]}}, pursuit_reg, 8'd0});
    assign rounded_full = total + 42'sd2048;
    assign rounded      = rounded_full[ACC_W-1:12];
    assign over         = !((rounded[29:23] == 7'h00) || (rounded[29:23] == 7'h7F));

    // Kick the CORDIC only when the pursuit term can be nonzero.
    assign start_next = (state_reg == S_MUL) && (step_reg == 3'd5) && need_reg
                        && (num_reg != '0);

    // Drop the valid when the result transfers, raise it when a new one loads.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_HOLD && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            err_reg       <= '0;
        end
        else
        begin
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (command)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            err_reg <= lateral_error;
                        end
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd5)
                    begin
                        if (start_next)
                        begin
                            state_reg <= S_VEC;
                        end
                        else
                        begin
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_VEC:
                begin
                    if (cordic_sts.done)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    // hold the result until the output register frees up
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_xfer && command)
        begin
            ax_reg     <= abs_x;
            ay_reg     <= abs_y;
            yaw_reg    <= target_heading;
            gy_neg_reg <= goal_y[FIELD_W-1];
            origin_reg <= (goal_x == '0) && (goal_y == '0);
            need_reg   <= (goal_y != '0);
        end
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                3'd1:    den_reg <= prod[WIDE_W-1:0];
                3'd2:    den_reg <= den_reg + prod[WIDE_W-1:0];
                3'd3:    num_reg <= {prod[WIDE_W-2:0], 1'b0};
                3'd4:    acc_reg <= prod[ACC_W-1:0];
                3'd5:
                begin
                    acc_reg     <= acc_reg + prod[ACC_W-1:0];
                    pursuit_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_VEC && cordic_sts.done)
        begin
            pursuit_reg <= gy_neg_reg ? -signed'({1'b0, cordic_angle})
                                      : signed'({1'b0, cordic_angle});
        end
        // load the output only once the previous result has left
        if (state_reg == S_HOLD && out_free)
        begin
            sat_out_reg    <= over;
            origin_out_reg <= origin_reg;
            if (!over)
            begin
                angle_out_reg <= rounded[FIELD_W-1:0];
            end
            else if (rounded[29])
            begin
                angle_out_reg <= 24'sh800000;
            end
            else
            begin
                angle_out_reg <= 24'sh7FFFFF;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign steering_angle = angle_out_reg;
    assign saturated      = sat_out_reg;
    assign goal_at_origin = origin_out_reg;

endmodule

// ===== hdl/lss_checker.sv =====
module lss_checker
    import lss_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      command,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [FIELD_W-1:0] steering_angle,
    input logic                      saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(steering_angle))
        else $error("stalled result changed");

    a_goal_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command |=> in_stall)
        else $error("goal transfer did not make the block busy");

    a_update_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !command |=> !in_stall)
        else $error("update transfer stalled the input");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (steering_angle == 24'sh7FFFFF) || (steering_angle == 24'sh800000))
        else $error("saturated flag without a clipped angle");

endmodule

bind lookahead_stanley_steering lss_checker u_lss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .steering_angle (steering_angle),
    .saturated      (saturated)
);

// ===== sim/lookahead_stanley_steering_tb.sv =====
module lookahead_stanley_steering_tb;
    import lss_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_enable;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      command;
    logic signed [FIELD_W-1:0] goal_x;
    logic signed [FIELD_W-1:0] goal_y;
    logic signed [YAW_W-1:0]   target_heading;
    logic signed [FIELD_W-1:0] lateral_error;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [FIELD_W-1:0] steering_angle;
    logic                      saturated;
    logic                      goal_at_origin;

    // Command codes on the input channel.
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_GOAL   = 1'b1;
    // Index 3 decodes to no register; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic                      cmd;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [YAW_W-1:0]   yaw;
        logic signed [FIELD_W-1:0] err;
        bit                        typed;
        logic signed [FIELD_W-1:0] angle;
        logic                      sat;
        logic                      org;
    } stim_row_t;

    typedef struct {
        logic signed [FIELD_W-1:0] angle;
        logic                      sat;
        logic                      org;
    } steer_t;

    lookahead_stanley_steering u_top (.*);

    // Predictor copy of the block's registers and stored cross-track error.
    logic [CFG_W-1:0]          wheelbase;
    logic signed [CFG_W-1:0]   yaw_gain;
    logic signed [CFG_W-1:0]   xtrack_gain;
    logic signed [FIELD_W-1:0] held_error;

    steer_t    pending_steer[$];
    stim_row_t directed_rows[$];
    int        mismatches;
    int        steer_count;
    int        goal_count;
    int        update_count;
    int        cycles;
    int        sender_idle;
    int        receiver_idle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Pursuit angle atan2(num, den) in Q.16 radians, both operands positive,
    // via a 16-step vectoring CORDIC on operands normalized to [2^29, 2^30).
    function automatic longint pursuit_angle(longint num, longint den);
        longint lim;
        longint a;
        longint b;
        longint vx;
        longint vy;
        longint z;
        longint sx;
        longint sy;
        lim = longint'(1) << 30;
        a = num;
        b = den;
        z = 0;
        while (a >= lim || b >= lim)
        begin
            a = a >> 1;
            b = b >> 1;
        end
        while (a < (lim >> 1) && b < (lim >> 1))
        begin
            a = a << 1;
            b = b << 1;
        end
        vx = b;
        vy = a;
        for (int i = 0; i < 16; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0)
            begin
                vx = vx + sy;
                vy = vy - sx;
                z  = z + longint'(atan_q16(ITER_W'(i)));
            end
            else
            begin
                vx = vx - sy;
                vy = vy + sx;
                z  = z - longint'(atan_q16(ITER_W'(i)));
            end
        end
        if (z < 0)
            z = 0;
        return z;
    endfunction

    function automatic steer_t steer_predict(logic signed [FIELD_W-1:0] x,
                                             logic signed [FIELD_W-1:0] y,
                                             logic signed [YAW_W-1:0] yaw);
        steer_t r;
        longint ax;
        longint ay;
        longint num;
        longint pursuit;
        longint total;
        longint res;
        pursuit = 0;
        r.org = (x == 0 && y == 0);
        r.sat = 1'b0;
        if (y != 0)
        begin
            ax = (x < 0) ? -longint'(x) : longint'(x);
            ay = (y < 0) ? -longint'(y) : longint'(y);
            num = 2 * longint'(wheelbase) * ay;
            if (num != 0)
            begin
                pursuit = pursuit_angle(num, ax * ax + ay * ay);
                if (y < 0)
                    pursuit = -pursuit;
            end
        end
        total = pursuit * 256 + longint'(held_error) * longint'(xtrack_gain)
              + longint'(yaw) * longint'(yaw_gain);
        res = (total + 2048) >>> 12;
        if (res > 8388607)
        begin
            res = 8388607;
            r.sat = 1'b1;
        end
        else if (res < -8388608)
        begin
            res = -8388608;
            r.sat = 1'b1;
        end
        r.angle = FIELD_W'(res);
        return r;
    endfunction

    // Pick a 24-bit field with weight on zero, the extremes and small values.
    function automatic logic signed [FIELD_W-1:0] pick_field();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 24'sh7FFFFF;
            2:       return 24'sh800000;
            3:       return FIELD_W'($urandom_range(131072) - 65536);
            4:       return FIELD_W'($urandom_range(8192) - 4096);
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [YAW_W-1:0] pick_yaw();
        case ($urandom_range(9))
            0:       return YAW_W'(12868);
            1:       return -YAW_W'(12868);
            2:       return YAW_W'($urandom);
            default: return YAW_W'($urandom_range(25736) - 12868);
        endcase
    endfunction

    // Present one transfer on the input channel and hold it until accepted.
    task automatic send_item(stim_row_t row);
        steer_t s;
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= row.cmd;
        goal_x         <= row.x;
        goal_y         <= row.y;
        target_heading <= row.yaw;
        lateral_error  <= row.err;
        do
            @(posedge clk);
        while (in_stall);
        if (row.cmd == CMD_UPDATE)
        begin
            held_error = row.err;
            update_count++;
        end
        else
        begin
            s = steer_predict(row.x, row.y, row.yaw);
            if (row.typed)
            begin
                s.angle = row.angle;
                s.sat   = row.sat;
                s.org   = row.org;
            end
            pending_steer.push_back(s);
            goal_count++;
        end
    endtask

    // Drain all steering results, then let a trailing update settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_steer.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(logic [CFG_W-1:0] wb, logic [CFG_W-1:0] hg,
                              logic [CFG_W-1:0] cg);
        cfg_write_enable <= 1'b1;
        cfg_index        <= REG_WHEELBASE;
        cfg_data         <= wb;
        @(posedge clk);
        wheelbase = wb;
        cfg_index <= REG_HEADING;
        cfg_data  <= hg;
        @(posedge clk);
        yaw_gain  = hg;
        cfg_index <= REG_CROSS;
        cfg_data  <= cg;
        @(posedge clk);
        xtrack_gain = cg;
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // Output side: stall at random and check each transfer in order.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_steer.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: angle %0d sat %0b origin %0b",
                             steering_angle, saturated, goal_at_origin);
            end
            else
            begin
                steer_t e;
                e = pending_steer.pop_front();
                steer_count++;
                if (e.angle !== steering_angle || e.sat !== saturated
                    || e.org !== goal_at_origin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected angle %0d sat %0b origin %0b, got %0d %0b %0b",
                                 e.angle, e.sat, e.org, steering_angle, saturated,
                                 goal_at_origin);
                end
            end
        end
        out_stall <= ($urandom_range(99) < receiver_idle);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t r;
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_UPDATE;
        goal_x = '0;
        goal_y = '0;
        target_heading = '0;
        lateral_error = '0;
        out_stall = 1'b0;
        mismatches = 0;
        steer_count = 0;
        goal_count = 0;
        update_count = 0;
        cycles = 0;
        sender_idle = 0;
        receiver_idle = 0;
        wheelbase = WHEELBASE_RESET;
        yaw_gain = HEADING_RESET;
        xtrack_gain = CROSS_RESET;
        held_error = '0;

        // Directed rows: origin, error and yaw extremes, axis goals, corners.
        directed_rows.push_back('{CMD_GOAL, 0, 0, 0, 0, 1, 0, 0, 1});
        directed_rows.push_back('{CMD_UPDATE, 5, 5, 5, 24'sh7FFFFF, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 0, 0, 0, 0, 1, 24'sh7FFFFF, 0, 1});
        directed_rows.push_back('{CMD_GOAL, 0, 0, 12868, 0, 1, 24'sh7FFFFF, 1, 1});
        directed_rows.push_back('{CMD_UPDATE, 0, 0, 0, 24'sh800000, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 0, 0, -12868, 0, 1, 24'sh800000, 1, 1});
        directed_rows.push_back('{CMD_UPDATE, -1, -1, -1, 0, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 4096, 0, 0, 0, 1, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 24'sh800000, 0, 0, 0, 1, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 0, 0, -16384, 0, 1, -16384, 0, 1});
        directed_rows.push_back('{CMD_GOAL, 0, 0, 16383, 0, 1, 16383, 0, 1});
        directed_rows.push_back('{CMD_GOAL, 0, 4096, 0, 0, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 0, -4096, 0, 0, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 24'sh7FFFFF, 24'sh7FFFFF, 12868, 0, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 24'sh800000, 24'sh800000, -12868, -1, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 1, 1, 1, 0, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, -1, 24'sh7FFFFF, 0, 0, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_UPDATE, 0, 0, 0, 12345, 0, 0, 0, 0});
        directed_rows.push_back('{CMD_GOAL, 20480, -8192, 2000, 24'sh555555, 0, 0, 0, 0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        wait_idle();

        // Random phases, each under its own register setting; the sender and receiver idle
        // rates swap after two phases and drop to zero for the last two.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_regs(WHEELBASE_RESET, HEADING_RESET, CROSS_RESET);
                1: write_regs(16'd0, 16'h8000, 16'h7FFF);
                2: write_regs(16'hFFFF, 16'h7FFF, 16'h8000);
                3: write_regs(16'hFFFF, 16'h0000, 16'h0000);
                default: write_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
            endcase
            sender_idle   = (phase < 2) ? 36 : (phase < 4) ? 51 : 0;
            receiver_idle = (phase < 2) ? 51 : (phase < 4) ? 36 : 0;
            for (int n = 0; n < 250; n++)
            begin
                r.cmd   = ($urandom_range(9) < 7) ? CMD_GOAL : CMD_UPDATE;
                r.x     = pick_field();
                r.y     = pick_field();
                r.yaw   = pick_yaw();
                r.err   = pick_field();
                r.typed = 1'b0;
                send_item(r);
            end
            wait_idle();
        end

        $display("covered %0d goal and %0d update transfers, %0d results checked",
                 goal_count, update_count, steer_count);
        $display("six register settings incl. extremes, three idle patterns, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_steer.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
